>>> design/scpc_pkg.sv
// Shared types, constants and helpers of the SEPIC charge PI controller.
package scpc_pkg;

	localparam int SAMPLE_FULL_SCALE = 32768;
	localparam int POT_MAX = 1023;

	localparam int ALU_W = 64;
	localparam int CNT_W = $clog2(ALU_W);

	localparam longint SAMPLE_LIMIT = longint'(38000) * 143 * 32750 *
		longint'(SAMPLE_FULL_SCALE) / (longint'(6144) * 1143 * 32768);
	localparam longint MV_MUL = longint'(6144) * 1143;
	localparam longint MV_DIV = longint'(143) * SAMPLE_FULL_SCALE;
	localparam longint CUR_MUL = 6144;
	localparam longint CUR_DIV = longint'(5) * SAMPLE_FULL_SCALE;
	localparam int SET_MIN_MV = 10000;
	localparam int SET_SPAN_MV = 4000;
	localparam int DIODE_MV = 300;
	localparam int TAPER_CURRENT = 250;
	localparam int MODE_LOW = 50;
	localparam int MODE_HIGH = 950;
	localparam int US_PER_S = 1000000;
	localparam int INT_SHIFT = 10;
	localparam int US_DIV = US_PER_S / 64;
	localparam int P_DIV = 1000;
	localparam longint I_DIV = longint'(1000) * 65536;
	localparam int FULL_COUNT = 255;
	localparam int EFF_ONE = 256;
	localparam int DUTY_FRAC = 8;
	localparam int ADJ_P_SHIFT = 8;
	localparam int ADJ_I_SHIFT = 24;

	localparam logic [1:0] MODE_OFF = 2'd0;
	localparam logic [1:0] MODE_LIGHT = 2'd1;
	localparam logic [1:0] MODE_BATT = 2'd2;

	localparam logic [1:0] PH_CC = 2'd0;
	localparam logic [1:0] PH_CV = 2'd1;
	localparam logic [1:0] PH_DONE = 2'd2;

	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_KP_CONV = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI_CONV = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KP_CHG = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KI_CHG = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CUR_TGT = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BAT_MAX = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_EFF = 4'd7;

	typedef struct packed {
		logic signed [15:0] out_sample;
		logic signed [15:0] battery_sample;
		logic signed [15:0] current_sample;
		logic signed [15:0] supply_sample;
		logic [9:0] setpoint_pot;
		logic [9:0] mode_pot;
		logic [31:0] now_us;
	} tick_t;

	typedef struct packed {
		logic [7:0] duty;
		logic [1:0] mode;
		logic light_enable;
		logic battery_enable;
		logic [1:0] charge_phase;
		logic [15:0] out_mv;
		logic [15:0] battery_mv;
		logic [15:0] battery_current;
	} res_t;

	typedef struct packed {
		logic start;
		logic is_div;
		logic signed [ALU_W-1:0] a;
		logic signed [ALU_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic signed [ALU_W-1:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic done;
		logic signed [ALU_W-1:0] quo;
		logic signed [ALU_W-1:0] rem;
	} div_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CONV_M,
		ST_CONV_D,
		ST_BRANCH,
		ST_C_PREP,
		ST_INT_M,
		ST_INT_D1,
		ST_INT_D2,
		ST_C_PM,
		ST_C_IM,
		ST_CV,
		ST_D_PREP,
		ST_FF_M,
		ST_FF_D,
		ST_P_M,
		ST_P_D,
		ST_I_M,
		ST_I_D,
		ST_SUM,
		ST_OUT
	} state_t;

	function automatic logic [ALU_W-1:0] mag64(input logic signed [ALU_W-1:0] v);
		return v[ALU_W-1] ? $unsigned(-v) : $unsigned(v);
	endfunction

endpackage

>>> design/scpc_mul.sv
// Bit-serial sign-magnitude multiplier, one multiplier bit per cycle.
module scpc_mul import scpc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input alu_req_t req,
	output mul_rsp_t rsp
);

	logic busy_q, done_q, neg_q;
	logic [ALU_W-1:0] ma_q, mb_q, acc_q;
	logic signed [ALU_W-1:0] prod_q;
	logic [ALU_W-1:0] acc_n, mb_n;

	always_comb begin
		acc_n = mb_q[0] ? acc_q + ma_q : acc_q;
		mb_n = mb_q >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !req.is_div) begin
				busy_q <= 1'b1;
			end else if (busy_q && mb_n == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// finish as soon as the multiplier bits run out
	always_ff @(posedge clk) begin
		if (req.start && !req.is_div) begin
			ma_q <= mag64(req.a);
			mb_q <= mag64(req.b);
			acc_q <= '0;
			neg_q <= req.a[ALU_W-1] ^ req.b[ALU_W-1];
		end else if (busy_q) begin
			acc_q <= acc_n;
			ma_q <= ma_q << 1;
			mb_q <= mb_n;
			if (mb_n == '0) begin
				prod_q <= neg_q ? -$signed(acc_n) : $signed(acc_n);
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = prod_q;

endmodule

>>> design/scpc_div.sv
// Restoring serial divider, one quotient bit per cycle, truncating toward zero.
module scpc_div import scpc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input alu_req_t req,
	output div_rsp_t rsp
);

	logic busy_q, done_q, nneg_q, qneg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [ALU_W-1:0] d_q, rem_q, quo_q;
	logic signed [ALU_W-1:0] q_q, r_q;
	logic [ALU_W:0] rem_sh;
	logic ge;
	logic [ALU_W-1:0] rem_n, quo_n;
	logic last;

	always_comb begin
		rem_sh = {rem_q, quo_q[ALU_W-1]};
		ge = rem_sh >= {1'b0, d_q};
		rem_n = ge ? ALU_W'(rem_sh - {1'b0, d_q}) : rem_sh[ALU_W-1:0];
		quo_n = {quo_q[ALU_W-2:0], ge};
		last = cnt_q == CNT_W'(ALU_W - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && req.is_div) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder takes the sign of the dividend
	always_ff @(posedge clk) begin
		if (req.start && req.is_div) begin
			d_q <= mag64(req.b);
			quo_q <= mag64(req.a);
			rem_q <= '0;
			nneg_q <= req.a[ALU_W-1];
			qneg_q <= req.a[ALU_W-1] ^ req.b[ALU_W-1];
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
			if (last) begin
				q_q <= qneg_q ? -$signed(quo_n) : $signed(quo_n);
				r_q <= nneg_q ? -$signed(rem_n) : $signed(rem_n);
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = q_q;
	assign rsp.rem = r_q;

endmodule

>>> design/sepic_charge_pi_controller_top.sv
// Top level of the SEPIC charge PI controller: sequencer, state and channels.
//
// Usage:
//  - tick channel (tick_valid / tick_stall / tick): one word per control tick
//    with four raw converter samples, two pot readings and a timestamp.
//  - res channel (res_valid / res_stall / res): one result word per tick with
//    duty, mode, enables, charge phase and the scaled measurements.
//  - cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register
//    writes, always ready; an index past the last register is dropped.
// Timing: one tick at a time. All arithmetic runs on a shared bit-serial
// multiplier and a 64-step serial divider, so a tick lasts longest in the
// constant-current phase, less in light mode and least in off mode; the
// divider (5 to 12 divisions per tick) dominates the length of a tick.
// tick_stall is high from acceptance until the result word is loaded into
// the output register, so the next tick is taken while a result still waits.
// Reset: registers return to their defaults, held samples, integrators,
// timestamps and target clear, mode is off, charge phase constant current.
// Receiver stall: the result word holds in the output register; once the
// next tick is done its result waits in the output step until the slot frees.
module sepic_charge_pi_controller_top import scpc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic tick_valid,
	output logic tick_stall,
	input tick_t tick,
	output logic res_valid,
	input logic res_stall,
	output res_t res,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [15:0] cfg_data
);

	localparam logic [2:0] CONV_OUT = 3'd0;
	localparam logic [2:0] CONV_BAT = 3'd1;
	localparam logic [2:0] CONV_CUR = 3'd2;
	localparam logic [2:0] CONV_SUP = 3'd3;
	localparam logic [2:0] CONV_SET = 3'd4;
	localparam logic [1:0] K_LIGHT = 2'd0;
	localparam logic [1:0] K_BATT = 2'd1;
	localparam logic [1:0] K_CHG = 2'd2;
	localparam logic signed [16:0] LIMIT = 17'(SAMPLE_LIMIT);

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		else if (v < -64'sd2147483648) return 32'sh80000000;
		else return v[31:0];
	endfunction

	function automatic logic signed [63:0] shr_trunc(input logic signed [63:0] v,
		input int unsigned sh);
		logic signed [63:0] bias;
		bias = v[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
		return (v + bias) >>> sh;
	endfunction

	function automatic logic [15:0] clamp16(input logic signed [31:0] v);
		if (v < 0) return 16'd0;
		else if (v > 32'sd65535) return 16'hFFFF;
		else return v[15:0];
	endfunction

	state_t state_q, state_n;
	logic issued_q;
	logic [2:0] conv_idx_q;

	// configuration registers
	logic [15:0] kp_conv_q, ki_conv_q, kp_chg_q, ki_chg_q, bmax_q;
	logic [13:0] cct_q;
	logic [7:0] max_duty_q;
	logic [8:0] eff_cfg_q;

	// controller state
	logic signed [15:0] held_q [4];
	logic signed [31:0] integ_q [3];
	logic [31:0] last_q [3];
	logic [1:0] mode_q, phase_q;
	logic signed [31:0] bt_q;

	// per-tick working registers
	logic [9:0] pot_set_q;
	logic [31:0] now_q;
	logic signed [31:0] vout_q, vbat_q, cur_q, vin_q, set_q;
	logic signed [31:0] err_q, num_q;
	logic signed [33:0] den_q;
	logic [1:0] k_q;
	logic [8:0] eff_q;
	logic signed [63:0] sum_q, mres_q, iq_q, adj_q;
	logic [7:0] duty_q;
	logic len_q, ben_q;

	logic res_valid_q;
	res_t res_q;

	alu_req_t alu_req;
	mul_rsp_t mul_rsp;
	div_rsp_t div_rsp;
	logic alu_done, is_op, tick_accept, res_load;

	logic signed [15:0] samp [4];
	logic signed [63:0] conv_a, conv_mul, conv_div;
	logic [31:0] dt;
	logic [16:0] ff_gain;
	logic signed [31:0] target, err_n, num_n;
	logic signed [63:0] tgt64, sum_sh;
	logic [7:0] duty_n;

	scpc_mul u_mul (.clk(clk), .arst_n(arst_n), .req(alu_req), .rsp(mul_rsp));
	scpc_div u_div (.clk(clk), .arst_n(arst_n), .req(alu_req), .rsp(div_rsp));

	assign alu_done = mul_rsp.done | div_rsp.done;
	assign tick_stall = state_q != ST_IDLE;
	assign tick_accept = tick_valid && !tick_stall;
	assign res_load = (state_q == ST_OUT) && (!res_valid_q || !res_stall);
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res = res_q;

	assign is_op = state_q == ST_CONV_M || state_q == ST_CONV_D ||
		state_q == ST_INT_M || state_q == ST_INT_D1 || state_q == ST_INT_D2 ||
		state_q == ST_C_PM || state_q == ST_C_IM || state_q == ST_FF_M ||
		state_q == ST_FF_D || state_q == ST_P_M || state_q == ST_P_D ||
		state_q == ST_I_M || state_q == ST_I_D;

	always_comb begin
		samp[0] = tick.out_sample;
		samp[1] = tick.battery_sample;
		samp[2] = tick.current_sample;
		samp[3] = tick.supply_sample;
	end

	// operands of the scaling steps
	always_comb begin
		conv_a = 64'(pot_set_q);
		conv_mul = 64'(SET_SPAN_MV);
		conv_div = 64'(POT_MAX);
		case (conv_idx_q)
			CONV_OUT: begin
				conv_a = 64'(held_q[0]);
				conv_mul = MV_MUL;
				conv_div = MV_DIV;
			end
			CONV_BAT: begin
				conv_a = 64'(held_q[1]);
				conv_mul = MV_MUL;
				conv_div = MV_DIV;
			end
			CONV_CUR: begin
				conv_a = 64'(held_q[2]);
				conv_mul = CUR_MUL;
				conv_div = CUR_DIV;
			end
			CONV_SUP: begin
				conv_a = 64'(held_q[3]);
				conv_mul = MV_MUL;
				conv_div = MV_DIV;
			end
			default: ;
		endcase
	end

	always_comb begin
		dt = now_q - last_q[k_q];
		ff_gain = 17'(eff_q * 17'(FULL_COUNT));
		target = (mode_q == MODE_LIGHT) ? set_q : bt_q;
		tgt64 = 64'(target);
		err_n = sat32(tgt64 - 64'(vout_q));
		num_n = sat32(tgt64 + 64'(DIODE_MV));
		sum_sh = sum_q >>> DUTY_FRAC;
		if (sum_q < 0) duty_n = 8'd0;
		else if (sum_sh > 64'(max_duty_q)) duty_n = max_duty_q;
		else duty_n = sum_sh[7:0];
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: if (tick_accept) state_n = ST_CONV_M;
			ST_CONV_M: if (alu_done) state_n = ST_CONV_D;
			ST_CONV_D: begin
				if (alu_done) state_n = (conv_idx_q == CONV_SET) ? ST_BRANCH : ST_CONV_M;
			end
			ST_BRANCH: begin
				case (mode_q)
					MODE_LIGHT: state_n = ST_D_PREP;
					MODE_BATT: begin
						if (phase_q == PH_CC) state_n = ST_C_PREP;
						else if (phase_q == PH_CV) state_n = ST_CV;
						else state_n = ST_D_PREP;
					end
					default: state_n = ST_OUT;
				endcase
			end
			ST_C_PREP: state_n = ST_INT_M;
			ST_INT_M: if (alu_done) state_n = ST_INT_D1;
			ST_INT_D1: if (alu_done) state_n = ST_INT_D2;
			ST_INT_D2: begin
				if (alu_done) begin
					if (k_q == K_CHG) state_n = ST_C_PM;
					else if (den_q > 0) state_n = ST_FF_M;
					else state_n = ST_P_M;
				end
			end
			ST_C_PM: if (alu_done) state_n = ST_C_IM;
			ST_C_IM: if (alu_done) state_n = ST_CV;
			ST_CV: state_n = ST_D_PREP;
			ST_D_PREP: state_n = ST_INT_M;
			ST_FF_M: if (alu_done) state_n = ST_FF_D;
			ST_FF_D: if (alu_done) state_n = ST_P_M;
			ST_P_M: if (alu_done) state_n = ST_P_D;
			ST_P_D: if (alu_done) state_n = ST_I_M;
			ST_I_M: if (alu_done) state_n = ST_I_D;
			ST_I_D: if (alu_done) state_n = ST_SUM;
			ST_SUM: state_n = ST_OUT;
			ST_OUT: if (res_load) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	// arithmetic request of each step
	always_comb begin
		alu_req.start = is_op && !issued_q;
		alu_req.is_div = 1'b0;
		alu_req.a = '0;
		alu_req.b = '0;
		unique case (state_q)
			ST_CONV_M: begin
				alu_req.a = conv_a;
				alu_req.b = conv_mul;
			end
			ST_CONV_D: begin
				alu_req.is_div = 1'b1;
				alu_req.a = mres_q;
				alu_req.b = conv_div;
			end
			ST_INT_M: begin
				alu_req.a = 64'(dt);
				alu_req.b = 64'(err_q);
			end
			ST_INT_D1, ST_INT_D2: begin
				alu_req.is_div = 1'b1;
				alu_req.a = mres_q;
				alu_req.b = 64'(US_DIV);
			end
			ST_C_PM: begin
				alu_req.a = 64'(err_q);
				alu_req.b = 64'(kp_chg_q);
			end
			ST_C_IM: begin
				alu_req.a = 64'(integ_q[k_q]);
				alu_req.b = 64'(ki_chg_q);
			end
			ST_FF_M: begin
				alu_req.a = 64'(num_q);
				alu_req.b = 64'(ff_gain);
			end
			ST_FF_D: begin
				alu_req.is_div = 1'b1;
				alu_req.a = mres_q;
				alu_req.b = 64'(den_q);
			end
			ST_P_M: begin
				alu_req.a = 64'(err_q);
				alu_req.b = 64'(kp_conv_q);
			end
			ST_P_D: begin
				alu_req.is_div = 1'b1;
				alu_req.a = mres_q;
				alu_req.b = 64'(P_DIV);
			end
			ST_I_M: begin
				alu_req.a = 64'(integ_q[k_q]);
				alu_req.b = 64'(ki_conv_q);
			end
			ST_I_D: begin
				alu_req.is_div = 1'b1;
				alu_req.a = mres_q;
				alu_req.b = I_DIV;
			end
			default: ;
		endcase
	end

	// control state, configuration and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issued_q <= 1'b0;
			kp_conv_q <= 16'd256;
			ki_conv_q <= 16'd563;
			kp_chg_q <= 16'd128;
			ki_chg_q <= 16'd282;
			cct_q <= 14'd2500;
			bmax_q <= 16'd14700;
			max_duty_q <= 8'd200;
			eff_cfg_q <= 9'd192;
			for (int i = 0; i < 4; i++) held_q[i] <= '0;
			for (int i = 0; i < 3; i++) begin
				integ_q[i] <= '0;
				last_q[i] <= '0;
			end
			mode_q <= MODE_OFF;
			phase_q <= PH_CC;
			bt_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (alu_done) issued_q <= 1'b0;
			else if (alu_req.start) issued_q <= 1'b1;

			if (cfg_valid) begin
				unique case (cfg_index)
					REG_KP_CONV: kp_conv_q <= cfg_data;
					REG_KI_CONV: ki_conv_q <= cfg_data;
					REG_KP_CHG: kp_chg_q <= cfg_data;
					REG_KI_CHG: ki_chg_q <= cfg_data;
					REG_CUR_TGT: cct_q <= cfg_data[13:0];
					REG_BAT_MAX: bmax_q <= cfg_data;
					REG_MAX_DUTY: max_duty_q <= cfg_data[7:0];
					REG_EFF: eff_cfg_q <= cfg_data[8:0];
					default: ;
				endcase
			end

			// drop samples at or above the limit, keep the held value
			if (tick_accept) begin
				for (int i = 0; i < 4; i++) begin
					if ($signed({samp[i][15], samp[i]}) < LIMIT) held_q[i] <= samp[i];
				end
				if (tick.mode_pot < MODE_LOW) mode_q <= MODE_BATT;
				else if (tick.mode_pot > MODE_LOW && tick.mode_pot < MODE_HIGH)
					mode_q <= MODE_OFF;
				else if (tick.mode_pot > MODE_HIGH) mode_q <= MODE_LIGHT;
			end

			if (state_q == ST_BRANCH && mode_q == MODE_OFF) begin
				for (int i = 0; i < 3; i++) integ_q[i] <= '0;
				bt_q <= '0;
				phase_q <= PH_CC;
			end

			if (state_q == ST_INT_D2 && alu_done) begin
				integ_q[k_q] <= sat32(64'(integ_q[k_q]) + (iq_q <<< INT_SHIFT) +
					div_rsp.quo);
				last_q[k_q] <= now_q;
			end

			if (state_q == ST_C_IM && alu_done) begin
				bt_q <= sat32(64'(vbat_q) + adj_q + shr_trunc(mul_rsp.prod, ADJ_I_SHIFT));
				if (vbat_q > $signed({16'd0, bmax_q})) phase_q <= PH_CV;
			end

			// constant voltage applies in the same tick it is entered
			if (state_q == ST_CV && phase_q == PH_CV) begin
				bt_q <= $signed({16'd0, bmax_q});
				if (cur_q < TAPER_CURRENT) phase_q <= PH_DONE;
			end

			if (res_load) begin
				res_valid_q <= 1'b1;
				for (int i = 0; i < 3; i++) begin
					if (held_q[i] < 0) held_q[i] <= '0;
				end
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// working registers of the current tick
	always_ff @(posedge clk) begin
		if (tick_accept) begin
			pot_set_q <= tick.setpoint_pot;
			now_q <= tick.now_us;
			conv_idx_q <= CONV_OUT;
		end
		case (state_q)
			ST_CONV_M, ST_INT_M, ST_FF_M, ST_P_M, ST_I_M: begin
				if (alu_done) mres_q <= mul_rsp.prod;
			end
			ST_CONV_D: begin
				if (alu_done) begin
					case (conv_idx_q)
						CONV_OUT: vout_q <= 32'(div_rsp.quo);
						CONV_BAT: vbat_q <= 32'(div_rsp.quo);
						CONV_CUR: cur_q <= 32'(div_rsp.quo);
						CONV_SUP: vin_q <= 32'(div_rsp.quo);
						default: set_q <= 32'(div_rsp.quo) + 32'(SET_MIN_MV);
					endcase
					conv_idx_q <= conv_idx_q + 3'd1;
				end
			end
			ST_BRANCH: begin
				duty_q <= 8'd0;
				len_q <= mode_q == MODE_LIGHT;
				ben_q <= mode_q == MODE_BATT && phase_q != PH_DONE;
			end
			ST_C_PREP: begin
				err_q <= sat32($signed({50'd0, cct_q}) - 64'(cur_q));
				k_q <= K_CHG;
			end
			ST_INT_D1: begin
				if (alu_done) begin
					iq_q <= div_rsp.quo;
					mres_q <= div_rsp.rem <<< INT_SHIFT;
				end
			end
			ST_C_PM: begin
				if (alu_done) adj_q <= shr_trunc(mul_rsp.prod, ADJ_P_SHIFT);
			end
			ST_CV: begin
				if (phase_q == PH_CV && cur_q < TAPER_CURRENT) ben_q <= 1'b0;
			end
			ST_D_PREP: begin
				err_q <= err_n;
				num_q <= num_n;
				den_q <= 34'(vin_q) + 34'(num_n);
				k_q <= (mode_q == MODE_LIGHT) ? K_LIGHT : K_BATT;
				eff_q <= (mode_q == MODE_LIGHT) ? eff_cfg_q : 9'(EFF_ONE);
				sum_q <= '0;
			end
			ST_FF_D, ST_P_D, ST_I_D: begin
				if (alu_done) sum_q <= sum_q + div_rsp.quo;
			end
			ST_SUM: duty_q <= duty_n;
			default: ;
		endcase
		if (res_load) begin
			res_q.duty <= duty_q;
			res_q.mode <= mode_q;
			res_q.light_enable <= len_q;
			res_q.battery_enable <= ben_q;
			res_q.charge_phase <= phase_q;
			res_q.out_mv <= clamp16(vout_q);
			res_q.battery_mv <= clamp16(vbat_q);
			res_q.battery_current <= clamp16(cur_q);
		end
	end

	a_res_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result word loaded outside the output step");

	a_off_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.mode == MODE_OFF) |->
		(res_q.duty == 8'd0 && !res_q.light_enable && !res_q.battery_enable))
		else $error("off mode result drives the converter");

	a_bat_enable: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.battery_enable) |->
		(res_q.mode == MODE_BATT && res_q.charge_phase != PH_DONE))
		else $error("battery switch on outside an active charge");

	a_done_issued: assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> issued_q)
		else $error("arithmetic result without a pending request");

endmodule

>>> dv/sepic_charge_pi_controller_top_test.sv
// Testbench of the SEPIC charge PI controller: directed and random ticks checked by a scoreboard.
module sepic_charge_pi_controller_top_test;
	import scpc_pkg::*;

	logic clk;
	logic arst_n;
	logic tick_valid;
	logic tick_stall;
	tick_t tick;
	logic res_valid;
	logic res_stall;
	res_t res;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0] cfg_data;

	sepic_charge_pi_controller_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.tick_valid(tick_valid),
		.tick_stall(tick_stall),
		.tick(tick),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Controller predictor plus the queue of result words still to come back.
	class charge_scoreboard;
		longint kp_conv, ki_conv, kp_chg, ki_chg, cur_tgt, bat_max, duty_max, eff;
		shortint held[4];
		logic [1:0] mode_now;
		logic [1:0] phase_now;
		int integ[3];
		int unsigned last_us[3];
		int bat_target;
		res_t pending_q[$];
		int errors;
		int checked;
		int light_ticks;
		int battery_ticks;
		int taper_ends;

		function new();
			kp_conv = 256; ki_conv = 563; kp_chg = 128; ki_chg = 282;
			cur_tgt = 2500; bat_max = 14700; duty_max = 200; eff = 192;
			foreach (held[i]) held[i] = 0;
			foreach (integ[i]) begin
				integ[i] = 0;
				last_us[i] = 0;
			end
			mode_now = MODE_OFF;
			phase_now = PH_CC;
			bat_target = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] d);
			case (idx)
				REG_KP_CONV: begin
					kp_conv = d;
				end
				REG_KI_CONV: begin
					ki_conv = d;
				end
				REG_KP_CHG: begin
					kp_chg = d;
				end
				REG_KI_CHG: begin
					ki_chg = d;
				end
				REG_CUR_TGT: begin
					cur_tgt = d[13:0];
				end
				REG_BAT_MAX: begin
					bat_max = d;
				end
				REG_MAX_DUTY: begin
					duty_max = d[7:0];
				end
				REG_EFF: begin
					eff = d[8:0];
				end
				default: begin
				end
			endcase
		endfunction

		function longint sat32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint scale_mv(shortint code);
			return longint'(code) * MV_MUL / MV_DIV;
		endfunction

		function void accumulate(int k, longint err, int unsigned now);
			int unsigned dt;
			longint prod, q, r, inc;
			dt = now - last_us[k];
			prod = longint'(dt) * sat32(err);
			q = prod / US_DIV;
			r = prod % US_DIV;
			inc = q * (1 << INT_SHIFT) + (r * (1 << INT_SHIFT)) / US_DIV;
			integ[k] = int'(sat32(longint'(integ[k]) + inc));
			last_us[k] = now;
		endfunction

		function logic [7:0] regulate(longint target, longint vin, longint vout, int k,
				int unsigned now, longint eff_q8);
			longint err, num, den, sum;
			err = sat32(target - vout);
			num = sat32(target + DIODE_MV);
			den = vin + num;
			sum = 0;
			if (den > 0) sum = num * FULL_COUNT * eff_q8 / den;
			accumulate(k, err, now);
			sum += err * kp_conv / P_DIV;
			sum += longint'(integ[k]) * ki_conv / I_DIV;
			sum /= 256;
			if (sum < 0) sum = 0;
			if (sum > duty_max) sum = duty_max;
			return sum[7:0];
		endfunction

		function logic [15:0] clamp16(longint v);
			if (v < 0) return 16'd0;
			if (v > 65535) return 16'hFFFF;
			return v[15:0];
		endfunction

		// Work out the result word of one accepted tick and queue it.
		function void note_tick(tick_t t);
			shortint s[4];
			longint vout, vbat, vin, cur, set_mv, err, adj;
			res_t r;
			s[0] = t.out_sample;
			s[1] = t.battery_sample;
			s[2] = t.current_sample;
			s[3] = t.supply_sample;
			foreach (s[i]) if (longint'(s[i]) < SAMPLE_LIMIT) held[i] = s[i];
			vout = scale_mv(held[0]);
			vbat = scale_mv(held[1]);
			cur = longint'(held[2]) * CUR_MUL / CUR_DIV;
			vin = scale_mv(held[3]);
			r = '0;
			if (t.mode_pot < MODE_LOW) mode_now = MODE_BATT;
			else if (t.mode_pot > MODE_LOW && t.mode_pot < MODE_HIGH) mode_now = MODE_OFF;
			else if (t.mode_pot > MODE_HIGH) mode_now = MODE_LIGHT;
			if (mode_now == MODE_LIGHT) begin
				set_mv = SET_MIN_MV + longint'(t.setpoint_pot) * SET_SPAN_MV / POT_MAX;
				r.duty = regulate(set_mv, vin, vout, 0, t.now_us, eff);
				r.light_enable = 1'b1;
				light_ticks++;
			end else if (mode_now == MODE_BATT) begin
				if (phase_now != PH_DONE) begin
					r.battery_enable = 1'b1;
					if (phase_now == PH_CC) begin
						err = cur_tgt - cur;
						accumulate(2, err, t.now_us);
						adj = err * kp_chg / 256 + longint'(integ[2]) * ki_chg / 16777216;
						bat_target = int'(sat32(vbat + adj));
						if (vbat > bat_max) phase_now = PH_CV;
					end
					if (phase_now == PH_CV) begin
						bat_target = int'(bat_max);
						if (cur < TAPER_CURRENT) begin
							phase_now = PH_DONE;
							r.battery_enable = 1'b0;
							taper_ends++;
						end
					end
				end
				r.duty = regulate(longint'(bat_target), vin, vout, 1, t.now_us, EFF_ONE);
				battery_ticks++;
			end else begin
				foreach (integ[i]) integ[i] = 0;
				bat_target = 0;
				phase_now = PH_CC;
			end
			r.mode = mode_now;
			r.charge_phase = phase_now;
			r.out_mv = clamp16(vout);
			r.battery_mv = clamp16(vbat);
			r.battery_current = clamp16(cur);
			for (int i = 0; i < 3; i++) if (held[i] < 0) held[i] = 0;
			pending_q.push_back(r);
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		task cmp(string name, longint got, longint want);
			if (got != want) report($sformatf("%s got %0d want %0d (result %0d)",
				name, got, want, checked));
		endtask

		task check_result(res_t got);
			res_t want;
			if (pending_q.size() == 0) begin
				report("result word with no tick outstanding");
				return;
			end
			want = pending_q.pop_front();
			cmp("duty", got.duty, want.duty);
			cmp("mode", got.mode, want.mode);
			cmp("light_enable", got.light_enable, want.light_enable);
			cmp("battery_enable", got.battery_enable, want.battery_enable);
			cmp("charge_phase", got.charge_phase, want.charge_phase);
			cmp("out_mv", got.out_mv, want.out_mv);
			cmp("battery_mv", got.battery_mv, want.battery_mv);
			cmp("battery_current", got.battery_current, want.battery_current);
			checked++;
		endtask
	endclass

	charge_scoreboard sb;
	int unsigned now_us;
	bit quiet;     // no idling on either side near the end of the run
	int gap_pct;   // chance of a sender gap before each word, varies per phase

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Sample both channels at the rising edge; drivers only move on the falling edge.
	always @(posedge clk) begin
		if (arst_n && tick_valid && !tick_stall) sb.note_tick(tick);
		if (arst_n && res_valid && !res_stall) sb.check_result(res);
	end

	// Receiver back-pressure: bursts of random length, each stalled with a chance of one in three.
	initial begin
		int len;
		bit stall_on;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (quiet) begin
				res_stall <= 1'b0;
			end else begin
				len = $urandom_range(1, 16);
				stall_on = ($urandom_range(0, 2) == 0);
				res_stall <= stall_on;
				repeat (len - 1) @(negedge clk);
			end
		end
	end

	// Present one tick word and hold it until it is taken; ends on a falling edge.
	task automatic send_tick(tick_t t);
		tick <= t;
		tick_valid <= 1'b1;
		do @(posedge clk); while (tick_stall);
		@(negedge clk);
	endtask

	// Drop valid for a burst of idle cycles, now and then.
	task automatic maybe_gap();
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			tick_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] d);
		cfg_index <= idx;
		cfg_data <= d;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, d);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Hold off until every outstanding result word has come back.
	task automatic drain();
		tick_valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(negedge clk);
		@(negedge clk);
	endtask

	// Register settings: extremes high, all zero, defaults, then random ones.
	task automatic load_setting(int k);
		logic [15:0] v[8];
		case (k)
			0: v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd10000, 16'd40000, 16'd255,
				16'd256};
			1: v = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
			2: v = '{16'd256, 16'd563, 16'd128, 16'd282, 16'd2500, 16'd14700, 16'd200,
				16'd192};
			default: v = '{16'($urandom_range(0, 2000)), 16'($urandom_range(0, 3000)),
				16'($urandom), 16'($urandom_range(0, 1500)), 16'($urandom_range(0, 10000)),
				16'($urandom_range(9000, 40000)), 16'($urandom_range(0, 255)),
				16'($urandom_range(0, 256))};
		endcase
		foreach (v[i]) write_reg(CFG_IDX_W'(i), v[i]);
		// An index past the register list must leave everything alone.
		write_reg(CFG_IDX_W'($urandom_range(8, 15)), 16'($urandom));
	endtask

	function automatic tick_t make_tick(shortint o, shortint b, shortint c, shortint s,
			int sp, int mp);
		tick_t t;
		t.out_sample = o;
		t.battery_sample = b;
		t.current_sample = c;
		t.supply_sample = s;
		t.setpoint_pot = 10'(sp);
		t.mode_pot = 10'(mp);
		t.now_us = now_us;
		return t;
	endfunction

	// Advance the timestamp: mostly kilohertz ticks, sometimes a long jump or a wrap.
	function automatic void advance_time();
		if ($urandom_range(0, 49) == 0) now_us += $urandom;
		else now_us += $urandom_range(50, 5000);
	endfunction

	function automatic int pot_for(logic [1:0] m);
		if ($urandom_range(0, 29) == 0) return ($urandom_range(0, 1) != 0) ? MODE_LOW : MODE_HIGH;
		case (m)
			MODE_BATT: return $urandom_range(0, MODE_LOW - 1);
			MODE_LIGHT: return $urandom_range(MODE_HIGH + 1, 1023);
			default: return $urandom_range(MODE_LOW + 1, MODE_HIGH - 1);
		endcase
	endfunction

	// One operating session: a charge run, a stretch of light mode, or off.
	task automatic run_session(ref int sent, input int total);
		int len, pick, bcode, ccode;
		logic [1:0] m;
		logic [127:0] noise;
		tick_t t;
		pick = $urandom_range(0, 9);
		m = (pick < 5) ? MODE_BATT : (pick < 8) ? MODE_LIGHT : MODE_OFF;
		len = $urandom_range(8, 40);
		bcode = $urandom_range(3000, 9500);
		ccode = $urandom_range(6000, 25000);
		repeat (len) begin
			if (sent >= total) return;
			advance_time();
			if ($urandom_range(0, 9) == 0) begin
				// noise: every field but the timestamp fully random
				noise = {$urandom, $urandom, $urandom, $urandom};
				t = noise[$bits(tick_t)-1:0];
				t.now_us = now_us;
			end else begin
				bcode += $urandom_range(0, 450);
				ccode -= $urandom_range(0, 1800);
				if (ccode < -500) ccode = $urandom_range(0, 3000);
				t = make_tick(shortint'($urandom_range(4000, 11000)), shortint'(bcode),
					shortint'(ccode), shortint'($urandom_range(3000, 16000)),
					$urandom_range(0, 1023), pot_for(m));
			end
			maybe_gap();
			send_tick(t);
			sent++;
			if (sent >= total - 200) quiet = 1'b1;
		end
	endtask

	initial begin
		int sent;
		int total;
		tick_t t;
		sb = new();
		arst_n = 1'b0;
		tick_valid = 1'b0;
		tick = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet = 1'b0;
		gap_pct = 30;
		now_us = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed ticks under the reset registers.
		// Mode pot edges: held on exactly 50 and 950.
		send_tick(make_tick(16'sd7000, 16'sd8000, 16'sd20000, 16'sd9000, 0, 0));
		now_us = 1000;
		send_tick(make_tick(16'sd7000, 16'sd8000, 16'sd20000, 16'sd9000, 1023, 49));
		now_us = 2000;
		send_tick(make_tick(16'sd7000, 16'sd8000, 16'sd20000, 16'sd9000, 0, MODE_LOW));
		send_tick(make_tick(16'sd7000, 16'sd8000, 16'sd20000, 16'sd9000, 0, 51));
		send_tick(make_tick(16'sd7000, 16'sd8000, 16'sd20000, 16'sd9000, 0, MODE_HIGH));
		now_us = 3000;
		send_tick(make_tick(16'sd7000, 16'sd8000, 16'sd20000, 16'sd9000, 0, 951));
		send_tick(make_tick(16'sd7000, 16'sd8000, 16'sd20000, 16'sd9000, 0, MODE_HIGH));
		now_us = 4000;
		send_tick(make_tick(16'sd7000, 16'sd8000, 16'sd20000, 16'sd9000, 1023, 1023));
		send_tick(make_tick(16'sd7000, 16'sd8000, 16'sd20000, 16'sd9000, 0, 949));
		// Sample limit: at and above are dropped, just below is taken.
		send_tick(make_tick(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 512, 1000));
		send_tick(make_tick(16'(SAMPLE_LIMIT), 16'(SAMPLE_LIMIT), 16'(SAMPLE_LIMIT),
			16'(SAMPLE_LIMIT), 512, 1000));
		send_tick(make_tick(16'(SAMPLE_LIMIT - 1), 16'(SAMPLE_LIMIT - 1),
			16'(SAMPLE_LIMIT - 1), 16'(SAMPLE_LIMIT - 1), 512, 1000));
		// Negative samples, supply so low that the feedforward divisor goes negative.
		now_us = 32'hFFFF_FF00;
		send_tick(make_tick(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1023, 1000));
		now_us = 32'h0000_0100;
		send_tick(make_tick(16'sd0, 16'sd0, 16'sd0, -16'sd32768, 0, 1000));
		send_tick(make_tick(-16'sd1, -16'sd1, -16'sd1, 16'sd0, 0, 0));
		// Battery above the limit with low current: constant voltage and done at once.
		now_us = 32'h0000_0500;
		send_tick(make_tick(16'sd9000, 16'sd12000, 16'sd2000, 16'sd9000, 0, 10));
		now_us = 32'h0000_0900;
		send_tick(make_tick(16'sd9000, 16'sd12000, 16'sd2000, 16'sd9000, 0, 10));
		// Off clears the charge session; then constant voltage without taper.
		send_tick(make_tick(16'sd9000, 16'sd12000, 16'sd2000, 16'sd9000, 0, 500));
		now_us = 32'h0000_1000;
		send_tick(make_tick(16'sd9000, 16'sd12000, 16'sd20000, 16'sd9000, 0, 0));
		now_us = 32'h0000_1400;
		send_tick(make_tick(16'sd9000, 16'sd12000, 16'sd1000, 16'sd9000, 0, 0));
		now_us = 32'hFFFF_FFFF;
		send_tick(make_tick(16'sd5000, 16'sd5000, 16'sd25000, 16'sd5000, 0, 0));
		drain();

		// Random sessions under a series of register settings.
		total = 1600;
		sent = 0;
		for (int k = 0; k < 5; k++) begin
			load_setting(k);
			gap_pct = (k == 2) ? 0 : $urandom_range(10, 60);
			while (sent < total * (k + 1) / 5) run_session(sent, total * (k + 1) / 5);
			if (k < 4) drain();
		end
		tick_valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);

		$display("Checked %0d result words: %0d light ticks, %0d battery ticks,",
			sb.checked, sb.light_ticks, sb.battery_ticks);
		$display("%0d charge runs tapered to done, 5 register settings plus reset values.",
			sb.taper_ends);
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Hard stop well past the slowest legal run.
	initial begin
		#40000000;
		$display("Timeout with %0d result words outstanding", sb.pending_q.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
